// File: design/threshold_run_pixel_sort_top_defines.svh
// assertion macros for the threshold run pixel sorter
// used by threshold_run_pixel_sort_top, expects clk and arst_n in scope
`ifndef THRESHOLD_RUN_PIXEL_SORT_TOP_DEFINES_SVH
`define THRESHOLD_RUN_PIXEL_SORT_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TRPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TRPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/trps_pkg.sv
// shared types, constants and the intensity function of the pixel sorter
// no dependencies
package trps_pkg;

	localparam int MAX_RUN = 32;
	localparam int CNT_W = $clog2(MAX_RUN + 1);
	localparam logic [7:0] THR_RESET = 8'd100;

	// divide by 3 through a reciprocal, exact for sums up to 765
	localparam int DIV3_MUL = 683;
	localparam int DIV3_SH = 11;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pix_t;

	typedef struct packed {
		pix_t px;
		logic [7:0] lev;
	} ent_t;

	typedef struct packed {
		logic ins;
		logic drn;
	} cell_ctrl_t;

	function automatic logic [7:0] px_level(pix_t p);
		logic [9:0] sum;
		logic [20:0] prod;
		sum = {2'b00, p.red} + {2'b00, p.green} + {2'b00, p.blue};
		prod = 21'(sum) * 21'(DIV3_MUL);
		return prod[DIV3_SH +: 8];
	endfunction

endpackage

// File: design/threshold_run_pixel_sort_top.sv
// top level of the threshold run pixel sorter: control, cell chain, output register
// depends on trps_pkg, trps_cell and threshold_run_pixel_sort_top_defines.svh
//
// Pixels of a line go in on the s_ beats and come out on the m_ beats. A pixel whose
// intensity (r+g+b)/3 reaches the threshold opens a run; the run is held in a chain of
// 32 sorting cells, kept in order of rising intensity as each pixel goes in, ties in
// arrival order. A pixel that only joins a run, or passes straight through, is handled
// in IDLE. A pixel that ends a run, or meets a full chain, first has the run drained
// and is then inserted or passed on; a line end drains the pixels still buffered.
// Draining goes through the head cell, one pixel a cycle while the output is free.
// m_tuser flags the last output beat caused by an input beat; m_tlast flags the
// final pixel of the line. The threshold resets to 100 and is written through cfg_we.
`include "threshold_run_pixel_sort_top_defines.svh"

module threshold_run_pixel_sort_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red, green, blue, alpha
	input  logic        s_tlast,   // line_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // out_red, out_green, out_blue, out_alpha
	output logic        m_tlast,   // out_line_end
	output logic        m_tuser    // burst_last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRE  = 2'd1;
	localparam logic [1:0] ST_ACT  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam int N = trps_pkg::MAX_RUN;
	localparam logic [trps_pkg::CNT_W-1:0] CNT_FULL = trps_pkg::CNT_W'(N);
	localparam logic [trps_pkg::CNT_W-1:0] CNT_ONE = trps_pkg::CNT_W'(1);

	logic [1:0] state_q, state_d;
	logic [7:0] thr_q;
	logic in_run_q;
	logic [trps_pkg::CNT_W-1:0] cnt_q;
	trps_pkg::pix_t px_q;
	logic [7:0] lev_q;
	logic ins_q, last_q;

	logic out_vld_q, out_last_q, out_user_q;
	trps_pkg::pix_t out_px_q;

	trps_pkg::pix_t in_px;
	logic [7:0] in_lev;
	logic acc, out_free, in_ins, in_pre;
	logic cnt_zero, cnt_one;

	trps_pkg::cell_ctrl_t ctrl;
	trps_pkg::ent_t new_ent;
	trps_pkg::ent_t ent [N];
	logic [N-1:0] vld, gt;

	logic emit;
	trps_pkg::pix_t emit_px;
	logic emit_last, emit_user;

	assign in_px = trps_pkg::pix_t'(s_tdata);
	assign in_lev = trps_pkg::px_level(in_px);
	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc = s_tvalid && s_tready;
	assign cnt_zero = (cnt_q == '0);
	assign cnt_one = (cnt_q == CNT_ONE);

	assign in_ins = (in_lev >= thr_q);
	// the open run is given out first when this pixel ends it or the chain is full
	assign in_pre = in_run_q && ((in_lev <= thr_q) || (cnt_q == CNT_FULL));

	always_comb begin
		new_ent.px = (state_q == ST_IDLE) ? in_px : px_q;
		new_ent.lev = (state_q == ST_IDLE) ? in_lev : lev_q;
		ctrl.ins = ((state_q == ST_IDLE) && acc && !in_pre && in_ins) ||
			((state_q == ST_ACT) && ins_q);
		ctrl.drn = ((state_q == ST_PRE) || (state_q == ST_FIN)) && out_free && !cnt_zero;
	end

	// sorted chain, head cell is index 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		trps_pkg::ent_t prev_ent, next_ent;
		logic prev_vld, prev_gt, next_vld;
		if (i == 0) begin : g_head
			assign prev_ent = new_ent;
			assign prev_vld = 1'b1;
			assign prev_gt = 1'b0;
		end else begin : g_body
			assign prev_ent = ent[i-1];
			assign prev_vld = vld[i-1];
			assign prev_gt = gt[i-1];
		end
		if (i == N - 1) begin : g_tail
			assign next_ent = new_ent;
			assign next_vld = 1'b0;
		end else begin : g_mid
			assign next_ent = ent[i+1];
			assign next_vld = vld[i+1];
		end
		trps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.new_ent  (new_ent),
			.prev_ent (prev_ent),
			.prev_vld (prev_vld),
			.prev_gt  (prev_gt),
			.next_ent (next_ent),
			.next_vld (next_vld),
			.ent      (ent[i]),
			.vld      (vld[i]),
			.gt       (gt[i])
		);
	end

	always_comb begin
		emit = 1'b0;
		emit_px = in_px;
		emit_last = 1'b0;
		emit_user = 1'b0;
		if ((state_q == ST_IDLE) && acc && !in_pre && !in_ins) begin
			emit = 1'b1;
			emit_last = s_tlast;
			emit_user = 1'b1;
		end else if ((state_q == ST_ACT) && !ins_q && out_free) begin
			emit = 1'b1;
			emit_px = px_q;
			emit_last = last_q;
			emit_user = 1'b1;
		end else if (ctrl.drn) begin
			emit = 1'b1;
			emit_px = ent[0].px;
			emit_last = (state_q == ST_FIN) && cnt_one;
			// last drained pixel ends the beat's output unless more follows
			emit_user = cnt_one && ((state_q == ST_FIN) || (ins_q && !last_q));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (in_pre) begin
						state_d = ST_PRE;
					end else if (in_ins && s_tlast) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_PRE: begin
				if (cnt_zero || (ctrl.drn && cnt_one)) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				if (ins_q) begin
					state_d = last_q ? ST_FIN : ST_IDLE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (cnt_zero || (ctrl.drn && cnt_one)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_q <= trps_pkg::THR_RESET;
			in_run_q <= 1'b0;
			cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (acc) begin
				in_run_q <= in_ins && !s_tlast;
			end
			if (ctrl.ins) begin
				cnt_q <= cnt_q + CNT_ONE;
			end else if (ctrl.drn) begin
				cnt_q <= cnt_q - CNT_ONE;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_q <= in_px;
			lev_q <= in_lev;
			ins_q <= in_ins;
			last_q <= s_tlast;
		end
		if (emit) begin
			out_px_q <= emit_px;
			out_last_q <= emit_last;
			out_user_q <= emit_user;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = 32'(out_px_q);
	assign m_tlast = out_last_q;
	assign m_tuser = out_user_q;

	`TRPS_ASSERT_IMP(a_cnt_vld, 1'b1, $countones(vld) == 32'(cnt_q), "count disagrees with chain")
	`TRPS_ASSERT_IMP(a_end_is_last, m_tvalid && m_tlast, m_tuser, "line end beat not burst end")
	`TRPS_ASSERT_IMP(a_buf_in_run, (state_q == ST_IDLE) && !cnt_zero, in_run_q,
		"pixels buffered outside a run")
	`TRPS_ASSERT_NXT(a_fin_drains, (state_q == ST_FIN) && ctrl.drn && cnt_one,
		(state_q == ST_IDLE) && cnt_zero, "final drain did not empty chain")

endmodule

// File: design/trps_cell.sv
// one cell of the sorted insertion chain: holds one buffered pixel and its level
// depends on trps_pkg
module trps_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  trps_pkg::cell_ctrl_t  ctrl,
	input  trps_pkg::ent_t        new_ent,
	input  trps_pkg::ent_t        prev_ent,
	input  logic                  prev_vld,
	input  logic                  prev_gt,
	input  trps_pkg::ent_t        next_ent,
	input  logic                  next_vld,
	output trps_pkg::ent_t        ent,
	output logic                  vld,
	output logic                  gt
);

	trps_pkg::ent_t ent_q;
	logic vld_q;
	logic take_new;

	// cell sorts after the new pixel, so the new one lands at or before it
	assign gt = vld_q && (ent_q.lev > new_ent.lev);
	// first cell whose neighbor before it stays put and that is free or greater
	assign take_new = prev_vld && !prev_gt && (gt || !vld_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (prev_gt || take_new) begin
				vld_q <= 1'b1;
			end
		end else if (ctrl.drn) begin
			vld_q <= next_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_gt) begin
				ent_q <= prev_ent;
			end else if (take_new) begin
				ent_q <= new_ent;
			end
		end else if (ctrl.drn) begin
			ent_q <= next_ent;
		end
	end

	assign ent = ent_q;
	assign vld = vld_q;

endmodule

// File: bench/trps_sort_checker.sv
// checker for the threshold run pixel sorter: predicts every output beat and compares it
// depends on trps_pkg; watches the threshold write port and both stream channels
`timescale 1ns / 1ps

module trps_sort_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	output int          err_count,
	output int          pending,
	output int          checked
);

	typedef struct {
		trps_pkg::pix_t px;
		logic line_end;
		logic burst_end;
	} pix_beat_t;

	pix_beat_t       due_pixels[$];
	trps_pkg::pix_t  run_buf[trps_pkg::MAX_RUN];
	int              run_len;
	logic            run_open;
	logic [7:0]      thr;

	function automatic int intensity(trps_pkg::pix_t p);
		return (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
	endfunction

	function automatic void emit_pixel(trps_pkg::pix_t p);
		pix_beat_t b;
		b.px = p;
		b.line_end = 1'b0;
		b.burst_end = 1'b0;
		due_pixels.insert(due_pixels.size(), b);
	endfunction

	// stable insertion sort, ties keep arrival order
	function automatic void drain_run();
		trps_pkg::pix_t ord[trps_pkg::MAX_RUN];
		trps_pkg::pix_t v;
		int j;
		for (int i = 0; i < run_len; i++) begin
			v = run_buf[i];
			j = i;
			while (j > 0 && intensity(ord[j - 1]) > intensity(v)) begin
				ord[j] = ord[j - 1];
				j--;
			end
			ord[j] = v;
		end
		for (int i = 0; i < run_len; i++)
			emit_pixel(ord[i]);
		run_len = 0;
	endfunction

	function automatic void buffer_pixel(trps_pkg::pix_t p);
		if (run_len >= trps_pkg::MAX_RUN)
			drain_run();
		run_buf[run_len] = p;
		run_len++;
	endfunction

	function automatic void sort_pixel(trps_pkg::pix_t p, logic eol);
		int n0;
		int lv;
		n0 = due_pixels.size();
		lv = intensity(p);
		if (!run_open) begin
			if (lv >= int'(thr)) begin
				run_open = 1'b1;
				buffer_pixel(p);
			end else begin
				emit_pixel(p);
			end
		end else if (lv > int'(thr)) begin
			buffer_pixel(p);
		end else begin
			drain_run();
			// a pixel right at the threshold opens the next run
			if (lv == int'(thr)) begin
				buffer_pixel(p);
			end else begin
				run_open = 1'b0;
				emit_pixel(p);
			end
		end
		if (eol) begin
			drain_run();
			run_open = 1'b0;
		end
		if (due_pixels.size() > n0) begin
			due_pixels[due_pixels.size() - 1].burst_end = 1'b1;
			due_pixels[due_pixels.size() - 1].line_end = eol;
		end
	endfunction

	function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	function automatic void check_beat();
		pix_beat_t want;
		trps_pkg::pix_t got;
		got = m_tdata;
		if (due_pixels.size() == 0) begin
			$error("output beat with nothing expected: tdata %h tlast %b tuser %b",
				m_tdata, m_tlast, m_tuser);
			err_count++;
			return;
		end
		want = due_pixels.pop_front();
		checked++;
		cmp_field("out_red", want.px.red, got.red);
		cmp_field("out_green", want.px.green, got.green);
		cmp_field("out_blue", want.px.blue, got.blue);
		cmp_field("out_alpha", want.px.alpha, got.alpha);
		cmp_field("out_line_end", {7'd0, want.line_end}, {7'd0, m_tlast});
		cmp_field("burst_last", {7'd0, want.burst_end}, {7'd0, m_tuser});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr = trps_pkg::THR_RESET;
			run_len = 0;
			run_open = 1'b0;
			due_pixels.delete();
			err_count = 0;
			checked = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				thr = cfg_wdata;
			// inputs first, so a same-edge pass-through would still find its expectation
			if (s_tvalid && s_tready)
				sort_pixel(trps_pkg::pix_t'(s_tdata), s_tlast);
			if (m_tvalid && m_tready)
				check_beat();
			pending = due_pixels.size();
		end
	end

endmodule

// File: bench/tb_top.sv
// top of the pixel sorter bench: clock, reset, pixel lines, threshold writes and verdict
// depends on trps_pkg, threshold_run_pixel_sort_top and trps_sort_checker
`timescale 1ns / 1ps

module tb_top;

	localparam int WATCHDOG_CYCLES = 3000;
	localparam int SETTLE_CYCLES = trps_pkg::MAX_RUN + 8;
	localparam int PHASE_ITEMS = 30;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int          errs;
	int          pending;
	int          checked;
	int          quiet = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          sent_px = 0;
	int          sent_lines = 0;
	int          thr_settings = 0;
	logic [7:0]  cur_thr = trps_pkg::THR_RESET;

	threshold_run_pixel_sort_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	trps_sort_checker i_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.err_count (errs),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// counts cycles in which no beat and no write happens
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic trps_pkg::pix_t rgba(int r, int g, int b, int a);
		trps_pkg::pix_t p;
		p.red = 8'(r);
		p.green = 8'(g);
		p.blue = 8'(b);
		p.alpha = 8'(a);
		return p;
	endfunction

	// random pixel whose intensity is exactly lv
	function automatic trps_pkg::pix_t at_level(int lv);
		int sum;
		int r;
		int g;
		sum = 3 * lv + $urandom_range(2);
		if (sum > 765)
			sum = 765;
		r = $urandom_range(sum > 255 ? 255 : sum, sum > 510 ? sum - 510 : 0);
		sum -= r;
		g = $urandom_range(sum > 255 ? 255 : sum, sum > 255 ? sum - 255 : 0);
		return rgba(r, g, sum - g, $urandom_range(255));
	endfunction

	// mostly near the threshold so runs open, grow, tie and break often
	function automatic trps_pkg::pix_t pick_pixel();
		int pick;
		int t;
		t = int'(cur_thr);
		pick = $urandom_range(99);
		if (pick < 15)
			return trps_pkg::pix_t'($urandom);
		if (pick < 32 && t > 0)
			return at_level($urandom_range(t - 1, 0));
		if (pick < 45 || t == 255)
			return at_level(t);
		return at_level($urandom_range(t < 235 ? t + 20 : 255, t + 1));
	endfunction

	task automatic send_pixel(trps_pkg::pix_t p, logic eol);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < send_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		s_tlast <= eol;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_px++;
		if (eol)
			sent_lines++;
	endtask

	// sender holds off until every expected beat is out and the chain has gone quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_thr = v;
		thr_settings++;
	endtask

	task automatic run_phase(logic [7:0] thr, idle_mode_t mode);
		int done;
		int len;
		settle();
		set_threshold(thr);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 64;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 64;
			end
			default: begin
				send_idle_pct = 27;
				recv_stall_pct = 27;
			end
		endcase
		done = 0;
		// low thresholds get a long first line so the chain fills up
		len = (thr < 50) ? $urandom_range(70, 33) : $urandom_range(20, 1);
		while (done < PHASE_ITEMS) begin
			for (int i = 0; i < len; i++)
				send_pixel(pick_pixel(), i == len - 1);
			done += len;
			len = ($urandom_range(99) < 10) ? $urandom_range(70, 33) : $urandom_range(20, 1);
		end
	endtask

	initial begin
		int thr_plan[8];
		thr_plan = '{0, 255, 100, 1, 254, -1, -1, 0};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed line work at the reset threshold of 100
		send_pixel(rgba(0, 0, 0, 0), 1'b0);
		send_pixel(rgba(255, 255, 255, 255), 1'b0);
		send_pixel(rgba(100, 100, 100, 8'h5a), 1'b0);
		send_pixel(rgba(255, 195, 0, 1), 1'b0);
		send_pixel(rgba(0, 105, 255, 2), 1'b0);
		send_pixel(rgba(120, 120, 120, 3), 1'b0);
		send_pixel(rgba(99, 100, 100, 4), 1'b0);
		send_pixel(rgba(0, 47, 255, 5), 1'b0);
		send_pixel(rgba(255, 50, 0, 6), 1'b1);
		send_pixel(rgba(1, 0, 0, 8'haa), 1'b1);
		send_pixel(rgba(200, 200, 200, 8'h55), 1'b1);
		send_pixel(rgba(180, 180, 180, 8'hf0), 1'b0);
		send_pixel(rgba(100, 101, 101, 8'h0f), 1'b1);
		send_pixel(rgba(0, 255, 0, 8'h80), 1'b0);
		send_pixel(rgba(0, 0, 255, 8'h7f), 1'b0);
		send_pixel(rgba(255, 0, 0, 255), 1'b1);

		for (int i = 0; i < 8; i++)
			run_phase(thr_plan[i] < 0 ? 8'($urandom_range(255)) : 8'(thr_plan[i]),
				idle_mode_t'(i % 4));

		settle();
		$display("tb_top: %0d pixels in %0d lines, %0d output beats compared",
			sent_px, sent_lines, checked);
		$display("tb_top: %0d threshold writes incl. 0 and 255, idle and stall on both sides",
			thr_settings);
		if (errs == 0 && pending == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+design
design/trps_pkg.sv
design/trps_cell.sv
design/threshold_run_pixel_sort_top.sv
bench/trps_sort_checker.sv
bench/tb_top.sv
